@@ rtl/ppp_pkg.sv @@
// shared types and constants for the perspective point projector
// no dependencies; used by every module of the block
package ppp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QBITS       = 17;
   localparam int NUM_WIDTH   = 64;
   localparam int DEN_WIDTH   = 46;
   localparam int CAM_WIDTH   = 38;
   localparam int CSR_WIDTH   = 48;
   localparam int CSR_IDX_W   = 4;

   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW0     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW1     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW2     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_X      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_Y      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_Z      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_LENGTH = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_SIZE   = 4'd7;

   localparam logic [47:0] ROT_ROW0_RST = 48'd16384;
   localparam logic [47:0] ROT_ROW1_RST = 48'd1073741824;
   localparam logic [47:0] ROT_ROW2_RST = 48'd70368744177664;
   localparam logic [23:0] FOCAL_RST    = 24'd131072;
   localparam logic [31:0] IMAGE_RST    = 32'd31457920;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pixel_col;
      logic signed [15:0] pixel_row;
      logic               saturated;
      logic               zero_depth;
   } rsp_type;

   typedef struct packed {
      logic [47:0]        rot_row0;
      logic [47:0]        rot_row1;
      logic [47:0]        rot_row2;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic [23:0]        focal;
      logic signed [16:0] cx;
      logic signed [16:0] base_row;
   } cfg_type;

   // numerators and denominator of one vertex, handed from front to back
   typedef struct packed {
      logic                         zero;
      logic signed [NUM_WIDTH-1:0]  nc;
      logic signed [NUM_WIDTH-1:0]  nr;
      logic signed [DEN_WIDTH-1:0]  d;
   } qent_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

@@ rtl/ppp_front.sv @@
// front end: accepts vertices, rotates and translates them, builds division operands
// depends on ppp_pkg
module ppp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppp_pkg::req_type  req_data,
   input  ppp_pkg::cfg_type  cfg,
   input  ppp_pkg::qstat_type qstat,
   output logic              push,
   output ppp_pkg::qent_type push_data
);

   localparam int CW = ppp_pkg::CAM_WIDTH;

   logic fe;
   logic a_v_ff, b_v_ff, c_v_ff;

   logic signed [47:0] pa_ff [3][3];
   logic signed [47:0] pa_in [3][3];
   logic signed [CW-1:0] cam_ff [3];
   logic signed [CW-1:0] cam_in [3];
   logic signed [62:0] pfx_ff, pfy_ff, pfx_in, pfy_in;
   logic signed [54:0] pcx_ff, pby_ff, pcx_in, pby_in;
   logic signed [CW-1:0] zc_ff;
   logic zero_ff, zero_in;

   logic signed [31:0] w [3];
   logic signed [31:0] t [3];
   logic [47:0] rows [3];

   assign fe = !(c_v_ff && qstat.full);
   assign req_stall = !fe;

   assign w[0] = req_data.world_x;
   assign w[1] = req_data.world_y;
   assign w[2] = req_data.world_z;
   assign t[0] = cfg.trans_x;
   assign t[1] = cfg.trans_y;
   assign t[2] = cfg.trans_z;
   assign rows[0] = cfg.rot_row0;
   assign rows[1] = cfg.rot_row1;
   assign rows[2] = cfg.rot_row2;

   // coefficient times world coordinate, exact
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            pa_in[r][j] = $signed(rows[r][16*j +: 16]) * w[j];
         end
      end
   end

   // row sum, floor shift to q.16, translation
   always_comb begin
      logic signed [49:0] s;
      for (int r = 0; r < 3; r++) begin
         s = 50'(pa_ff[r][0]) + 50'(pa_ff[r][1]) + 50'(pa_ff[r][2]);
         cam_in[r] = CW'(s >>> 14) + CW'(t[r]);
      end
   end

   assign pfx_in  = $signed({1'b0, cfg.focal}) * cam_ff[0];
   assign pfy_in  = $signed({1'b0, cfg.focal}) * cam_ff[1];
   assign pcx_in  = cfg.cx * cam_ff[2];
   assign pby_in  = cfg.base_row * cam_ff[2];
   assign zero_in = (cam_ff[2] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (fe) begin
         a_v_ff <= req_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         pa_ff   <= pa_in;
         cam_ff  <= cam_in;
         pfx_ff  <= pfx_in;
         pfy_ff  <= pfy_in;
         pcx_ff  <= pcx_in;
         pby_ff  <= pby_in;
         zc_ff   <= cam_ff[2];
         zero_ff <= zero_in;
      end
   end

   // numerators with depth d = zc * 256
   assign push = c_v_ff && fe;
   assign push_data.zero = zero_ff;
   assign push_data.nc   = (64'(pcx_ff) <<< 8) - 64'(pfx_ff);
   assign push_data.nr   = (64'(pby_ff) <<< 8) + 64'(pfy_ff);
   assign push_data.d    = 46'(zc_ff) <<< 8;

endmodule

@@ rtl/ppp_queue.sv @@
// short queue that decouples the front end from the divider back end
// depends on ppp_pkg
module ppp_queue #(
   parameter int DEPTH = ppp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ppp_pkg::qent_type   push_data,
   input  logic                pop,
   output ppp_pkg::qent_type   pop_data,
   output ppp_pkg::qstat_type  qstat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   ppp_pkg::qent_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   assign wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop) rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data    = mem_ff[rd_ff];
   assign qstat.empty = (cnt_ff == '0);
   assign qstat.full  = (cnt_ff == CNTW'(DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push || pop)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

@@ rtl/ppp_back.sv @@
// back end: pipelined restoring divider, one quotient bit per stage, and output register
// depends on ppp_pkg
module ppp_back (
   input  logic               clock,
   input  logic               reset,
   input  ppp_pkg::qstat_type qstat,
   output logic               pop,
   input  ppp_pkg::qent_type  pop_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ppp_pkg::rsp_type   rsp_data
);

   localparam int QB   = ppp_pkg::QBITS;
   localparam int NW   = ppp_pkg::NUM_WIDTH;
   localparam int DW   = ppp_pkg::DEN_WIDTH;
   localparam int NSTG = QB + 2;

   typedef struct packed {
      logic          valid;
      logic          zero;
      logic          neg_c;
      logic          neg_r;
      logic          ovf_c;
      logic          ovf_r;
      logic [DW-1:0] ad;
      logic [NW-1:0] rem_c;
      logic [NW-1:0] rem_r;
      logic [QB-1:0] q_c;
      logic [QB-1:0] q_r;
   } div_stage_type;

   div_stage_type stg_ff [NSTG];
   div_stage_type stg_in [NSTG];
   logic be;
   logic rsp_valid_ff;
   ppp_pkg::rsp_type rsp_ff, rsp_in;

   assign be  = !(rsp_valid_ff && rsp_stall);
   assign pop = be && !qstat.empty;

   // clamp a magnitude quotient with its sign to 16 bits
   function automatic logic [16:0] clamp_q(input logic neg, input logic ovf,
                                          input logic [QB-1:0] q);
      logic [16:0] res;
      if (neg) begin
         if (ovf || q > QB'(32768)) res = {1'b1, 16'h8000};
         else res = {1'b0, 16'(-q)};
      end else begin
         if (ovf || q > QB'(32767)) res = {1'b1, 16'h7fff};
         else res = {1'b0, q[15:0]};
      end
      return res;
   endfunction

   always_comb begin
      logic [NW-1:0] dv;
      // magnitudes and quotient signs
      stg_in[0]       = '0;
      stg_in[0].valid = !qstat.empty;
      stg_in[0].zero  = pop_data.zero;
      stg_in[0].neg_c = pop_data.nc[NW-1] ^ pop_data.d[DW-1];
      stg_in[0].neg_r = pop_data.nr[NW-1] ^ pop_data.d[DW-1];
      stg_in[0].ad    = pop_data.d[DW-1] ? DW'(-pop_data.d) : DW'(pop_data.d);
      stg_in[0].rem_c = pop_data.nc[NW-1] ? NW'(-pop_data.nc) : NW'(pop_data.nc);
      stg_in[0].rem_r = pop_data.nr[NW-1] ? NW'(-pop_data.nr) : NW'(pop_data.nr);
      // quotient too wide for the bit steps
      stg_in[1]       = stg_ff[0];
      dv              = NW'(stg_ff[0].ad) << QB;
      stg_in[1].ovf_c = (stg_ff[0].rem_c >= dv);
      stg_in[1].ovf_r = (stg_ff[0].rem_r >= dv);
      // one restoring step per stage, msb first
      for (int i = 0; i < QB; i++) begin
         stg_in[i+2] = stg_ff[i+1];
         dv = NW'(stg_ff[i+1].ad) << (QB - 1 - i);
         if (stg_ff[i+1].rem_c >= dv) begin
            stg_in[i+2].rem_c = stg_ff[i+1].rem_c - dv;
            stg_in[i+2].q_c[QB-1-i] = 1'b1;
         end
         if (stg_ff[i+1].rem_r >= dv) begin
            stg_in[i+2].rem_r = stg_ff[i+1].rem_r - dv;
            stg_in[i+2].q_r[QB-1-i] = 1'b1;
         end
      end
   end

   always_comb begin
      logic [16:0] cc, rr;
      cc = clamp_q(stg_ff[NSTG-1].neg_c, stg_ff[NSTG-1].ovf_c, stg_ff[NSTG-1].q_c);
      rr = clamp_q(stg_ff[NSTG-1].neg_r, stg_ff[NSTG-1].ovf_r, stg_ff[NSTG-1].q_r);
      if (stg_ff[NSTG-1].zero) begin
         rsp_in.pixel_col  = '0;
         rsp_in.pixel_row  = '0;
         rsp_in.saturated  = 1'b0;
         rsp_in.zero_depth = 1'b1;
      end else begin
         rsp_in.pixel_col  = cc[15:0];
         rsp_in.pixel_row  = rr[15:0];
         rsp_in.saturated  = cc[16] | rr[16];
         rsp_in.zero_depth = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) stg_ff[i].valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (be) begin
         stg_ff       <= stg_in;
         rsp_valid_ff <= stg_ff[NSTG-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (be) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_depth |->
         rsp_data.pixel_col == 16'sd0 && rsp_data.pixel_row == 16'sd0 && !rsp_data.saturated)
      else $error("zero depth result carries nonzero fields");
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.pixel_col == 16'sh7fff || rsp_data.pixel_col == 16'sh8000 ||
         rsp_data.pixel_row == 16'sh7fff || rsp_data.pixel_row == 16'sh8000)
      else $error("saturated flag without a clamped coordinate");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("divider pipeline moved under output stall");

endmodule

@@ rtl/perspective_point_projector_core.sv @@
// top level of the perspective point projector: registers, front end, queue, divider back end
// depends on ppp_pkg, ppp_front, ppp_queue, ppp_back
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  ppp_pkg::req_type (world x, y, z, q16.16)
//  rsp      out        rsp_valid/rsp_stall  ppp_pkg::rsp_type (column, row, flags)
//  csr      in         csr_we               csr_index, csr_wdata (write only)
//
// one vertex per clock sustained while the output is not stalled
// the path from accept to result is 3 front stages, one queue slot, 19 divider stages (magnitudes,
// overflow check, then one per quotient bit) and the output register, the first stage loading at accept
// synchronous active-high reset clears pipeline valids, queue pointers and registers;
// no clearing pass
// an output stall freezes the divider; the queue absorbs the front end until full
module perspective_point_projector_core #(
   parameter int QUEUE_DEPTH = ppp_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ppp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ppp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppp_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   logic [47:0] rot0_ff, rot1_ff, rot2_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff;
   logic [23:0] focal_ff;
   logic [31:0] img_ff;

   // configuration registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff  <= ppp_pkg::ROT_ROW0_RST;
         rot1_ff  <= ppp_pkg::ROT_ROW1_RST;
         rot2_ff  <= ppp_pkg::ROT_ROW2_RST;
         tx_ff    <= '0;
         ty_ff    <= '0;
         tz_ff    <= '0;
         focal_ff <= ppp_pkg::FOCAL_RST;
         img_ff   <= ppp_pkg::IMAGE_RST;
      end else if (csr_we) begin
         case (csr_index)
            ppp_pkg::REG_ROT_ROW0:     rot0_ff  <= csr_wdata;
            ppp_pkg::REG_ROT_ROW1:     rot1_ff  <= csr_wdata;
            ppp_pkg::REG_ROT_ROW2:     rot2_ff  <= csr_wdata;
            ppp_pkg::REG_TRANS_X:      tx_ff    <= csr_wdata[31:0];
            ppp_pkg::REG_TRANS_Y:      ty_ff    <= csr_wdata[31:0];
            ppp_pkg::REG_TRANS_Z:      tz_ff    <= csr_wdata[31:0];
            ppp_pkg::REG_FOCAL_LENGTH: focal_ff <= csr_wdata[23:0];
            ppp_pkg::REG_IMAGE_SIZE:   img_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // image centres; an empty dimension gives centre zero and a base row of minus one
   logic [15:0] wm1, hm1;
   ppp_pkg::cfg_type cfg;
   assign wm1 = img_ff[15:0] - 16'd1;
   assign hm1 = img_ff[31:16] - 16'd1;

   assign cfg.rot_row0 = rot0_ff;
   assign cfg.rot_row1 = rot1_ff;
   assign cfg.rot_row2 = rot2_ff;
   assign cfg.trans_x  = tx_ff;
   assign cfg.trans_y  = ty_ff;
   assign cfg.trans_z  = tz_ff;
   assign cfg.focal    = focal_ff;
   assign cfg.cx       = (img_ff[15:0] == 16'd0) ? 17'sd0 : $signed({1'b0, wm1 >> 1});
   assign cfg.base_row = (img_ff[31:16] == 16'd0) ? -17'sd1
                                                   : $signed({1'b0, hm1 - (hm1 >> 1)});

   logic push, pop;
   ppp_pkg::qent_type push_data, pop_data;
   ppp_pkg::qstat_type qstat;

   ppp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   ppp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   ppp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/perspective_point_projector_core_tb.sv @@
// self-checking testbench for perspective_point_projector_core
// depends on ppp_pkg and the core; predicts each projected vertex in exact integer math
module perspective_point_projector_core_tb;

   localparam int LATENCY   = 24;
   localparam int MAX_CYCLE = 400000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   ppp_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   ppp_pkg::rsp_type              rsp_data;
   logic                          csr_we = 1'b0;
   logic [ppp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ppp_pkg::CSR_WIDTH-1:0] csr_wdata = '0;

   perspective_point_projector_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // testbench copy of the camera registers
   logic [47:0]        cam_rot [3];
   logic signed [31:0] cam_trans [3];
   logic [23:0]        cam_focal;
   logic [31:0]        cam_size;

   ppp_pkg::req_type vertex_q [$];
   ppp_pkg::rsp_type pixel_q [$];
   int      errors = 0;
   int      cycle = 0;
   int      rx_hold = 0;     // long receiver hold-off, counted in cycles
   bit      rx_hold_req = 0;
   bit      tx_pause = 0;    // sender holds off new transactions

   function automatic longint floor14(longint v);
      if (v >= 0) return v >>> 14;
      return -(((-v) - 1) >>> 14) - 1;
   endfunction

   function automatic longint clip16(longint v, ref bit sat);
      if (v > 32767) begin
         sat = 1;
         return 32767;
      end
      if (v < -32768) begin
         sat = 1;
         return -32768;
      end
      return v;
   endfunction

   function automatic ppp_pkg::rsp_type project_vertex(ppp_pkg::req_type v);
      longint w [3];
      longint cam [3];
      longint acc, f, wd, ht, cx, cy, brow, d, nc, nr;
      logic signed [15:0] c;
      ppp_pkg::rsp_type r;
      bit sat;
      sat = 0;
      w[0] = v.world_x;
      w[1] = v.world_y;
      w[2] = v.world_z;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            c = cam_rot[i][16*j +: 16];
            acc += longint'(c) * w[j];
         end
         cam[i] = floor14(acc) + longint'(cam_trans[i]);
      end
      r = '0;
      if (cam[2] == 0) begin
         r.zero_depth = 1'b1;
         return r;
      end
      f = cam_focal;
      wd = cam_size[15:0];
      ht = cam_size[31:16];
      cx = (wd - 1) / 2;
      cy = (ht - 1) / 2;
      brow = (ht - 1) - cy;
      d = cam[2] * 256;
      nc = cx * d - f * cam[0];
      nr = brow * d + f * cam[1];
      if (d < 0) begin
         d = -d;
         nc = -nc;
         nr = -nr;
      end
      r.pixel_col = 16'(clip16(nc / d, sat));
      r.pixel_row = 16'(clip16(nr / d, sat));
      r.saturated = sat;
      return r;
   endfunction

   // driver: one transaction from the pending queue, random gap between items
   int tx_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pixel_q.insert(pixel_q.size(), project_vertex(req_data));
            tx_gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) tx_gap = 0;
         end
         if (req_valid && req_stall) begin
            // stalled: hold payload
         end else if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (!tx_pause && vertex_q.size() > 0) begin
            req_data <= vertex_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each accepted result, then draw the next stall
   int rx_gap = 0;
   always @(posedge clock) begin
      cycle++;
      if (cycle > MAX_CYCLE) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected result col=%0d row=%0d", rsp_data.pixel_col, rsp_data.pixel_row);
               errors++;
            end else begin
               ppp_pkg::rsp_type e;
               e = pixel_q.pop_front();
               if (rsp_data.pixel_col !== e.pixel_col) begin
                  $error("pixel_col expected %0d actual %0d", e.pixel_col, rsp_data.pixel_col);
                  errors++;
               end
               if (rsp_data.pixel_row !== e.pixel_row) begin
                  $error("pixel_row expected %0d actual %0d", e.pixel_row, rsp_data.pixel_row);
                  errors++;
               end
               if (rsp_data.saturated !== e.saturated) begin
                  $error("saturated expected %0b actual %0b", e.saturated, rsp_data.saturated);
                  errors++;
               end
               if (rsp_data.zero_depth !== e.zero_depth) begin
                  $error("zero_depth expected %0b actual %0b", e.zero_depth, rsp_data.zero_depth);
                  errors++;
               end
            end
            rx_gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) rx_gap = 0;
         end
         if (rx_hold_req) begin
            rx_hold_req = 0;
            rx_hold = 200;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(logic [ppp_pkg::CSR_IDX_W-1:0] idx,
                            logic [ppp_pkg::CSR_WIDTH-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ppp_pkg::REG_ROT_ROW0:     cam_rot[0] = val[47:0];
         ppp_pkg::REG_ROT_ROW1:     cam_rot[1] = val[47:0];
         ppp_pkg::REG_ROT_ROW2:     cam_rot[2] = val[47:0];
         ppp_pkg::REG_TRANS_X:      cam_trans[0] = val[31:0];
         ppp_pkg::REG_TRANS_Y:      cam_trans[1] = val[31:0];
         ppp_pkg::REG_TRANS_Z:      cam_trans[2] = val[31:0];
         ppp_pkg::REG_FOCAL_LENGTH: cam_focal = val[23:0];
         ppp_pkg::REG_IMAGE_SIZE:   cam_size = val[31:0];
         default: ;   // out-of-range index is ignored
      endcase
   endtask

   // wait for the block to drain before touching registers
   task automatic drain();
      while (vertex_q.size() > 0 || req_valid || pixel_q.size() > 0) @(negedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] coef(int k);
      case (k)
         0: return 16'h4000;
         1: return 16'h0000;
         2: return 16'hC000;
         3: return 16'h7FFF;
         4: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         3: return 32'($urandom);
         default: return 32'($signed($urandom_range(0, 400000)) - 200000) <<< 4;
      endcase
   endfunction

   task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      ppp_pkg::req_type v;
      v.world_x = x;
      v.world_y = y;
      v.world_z = z;
      vertex_q.insert(vertex_q.size(), v);
   endtask

   initial begin
      cam_rot[0] = ppp_pkg::ROT_ROW0_RST;
      cam_rot[1] = ppp_pkg::ROT_ROW1_RST;
      cam_rot[2] = ppp_pkg::ROT_ROW2_RST;
      cam_trans[0] = 0;
      cam_trans[1] = 0;
      cam_trans[2] = 0;
      cam_focal = ppp_pkg::FOCAL_RST;
      cam_size = ppp_pkg::IMAGE_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset camera, extremes, zero depth, behind camera, saturation
      add_vertex(32'h00010000, 32'h00020000, 32'h000A0000);
      add_vertex(32'h0, 32'h0, 32'h0);                          // zero depth
      add_vertex(32'h00010000, 32'h00010000, 32'hFFF60000);     // behind camera
      add_vertex(32'h7FFFFFFF, 32'h80000000, 32'h00000001);     // saturates
      add_vertex(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      add_vertex(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      add_vertex(32'h12345678, 32'hEDCBA987, 32'h00001000);
      drain();
      // extreme registers, plus an ignored index
      write_reg(ppp_pkg::REG_ROT_ROW0, {16'h8000, 16'h7FFF, 16'h7FFF});
      write_reg(ppp_pkg::REG_ROT_ROW1, {16'h7FFF, 16'h8000, 16'h8000});
      write_reg(ppp_pkg::REG_ROT_ROW2, {16'h7FFF, 16'h7FFF, 16'h8000});
      write_reg(ppp_pkg::REG_TRANS_X, 32'h7FFFFFFF);
      write_reg(ppp_pkg::REG_TRANS_Y, 32'h80000000);
      write_reg(ppp_pkg::REG_TRANS_Z, 32'h7FFFFFFF);
      write_reg(ppp_pkg::REG_FOCAL_LENGTH, 24'hFFFFFF);
      write_reg(ppp_pkg::REG_IMAGE_SIZE, 32'hFFFFFFFF);
      write_reg(4'd9, 48'hFFFFFFFFFFFF);
      add_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      add_vertex(32'h80000000, 32'h80000000, 32'h80000000);
      add_vertex(32'h0, 32'h0, 32'h0);
      drain();
      write_reg(ppp_pkg::REG_IMAGE_SIZE, 32'h0);                // zero width and height
      write_reg(ppp_pkg::REG_FOCAL_LENGTH, 24'h0);
      write_reg(ppp_pkg::REG_TRANS_Z, 32'h00010000);
      write_reg(ppp_pkg::REG_ROT_ROW2, 48'h0);
      add_vertex(32'h00050000, 32'hFFFB0000, 32'h00010000);
      add_vertex(32'h0, 32'h0, 32'h0);
      drain();

      // random phases with varying camera setups
      for (int ph = 0; ph < 11; ph++) begin
         int pick;
         pick = (ph < 5) ? ph : 5;
         write_reg(ppp_pkg::REG_ROT_ROW0,
                   {coef(pick), coef(pick == 0 ? 1 : pick), coef(pick)});
         write_reg(ppp_pkg::REG_ROT_ROW1,
                   {coef(pick), coef(pick), coef(pick == 0 ? 1 : pick)});
         write_reg(ppp_pkg::REG_ROT_ROW2,
                   {coef(pick == 0 ? 0 : pick), coef(pick), coef(pick)});
         write_reg(ppp_pkg::REG_TRANS_X,
                   ph == 1 ? 32'h80000000 : 32'($urandom) >>> $urandom_range(0, 31));
         write_reg(ppp_pkg::REG_TRANS_Y, 32'($urandom) >>> $urandom_range(0, 31));
         write_reg(ppp_pkg::REG_TRANS_Z,
                   ph == 2 ? 32'h0 : 32'($urandom) >>> $urandom_range(0, 31));
         write_reg(ppp_pkg::REG_FOCAL_LENGTH, ph == 3 ? 24'h0 : 24'($urandom));
         write_reg(ppp_pkg::REG_IMAGE_SIZE, ph == 4 ? 32'h00010001 : 32'($urandom));
         for (int n = 0; n < 100; n++)
            add_vertex(rand_coord(), rand_coord(), rand_coord());
         // long receiver hold-off while the sender keeps offering
         if (ph == 6) rx_hold_req = 1;
         // sender pause until every expected result has come, then continue
         if (ph == 8) begin
            while (vertex_q.size() > 50) @(posedge clock);
            tx_pause = 1;
            @(negedge clock);
            while (req_valid || pixel_q.size() > 0) @(negedge clock);
            tx_pause = 0;
         end
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_queue.sv
rtl/ppp_back.sv
rtl/perspective_point_projector_core.sv
tb/perspective_point_projector_core_tb.sv
